// File: hdl/rgbe_rle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rgbe_rle_pkg
// Types and constants shared by the RGBE scanline run-length decoder.
// -----------------------------------------------------------------------------
package rgbe_rle_pkg;

  // Decoder phase, one per kind of byte expected next
  typedef enum logic [3:0] {
    PH_HDR0     = 4'd0,
    PH_HDR1     = 4'd1,
    PH_HDR2     = 4'd2,
    PH_HDR3     = 4'd3,
    PH_CODE     = 4'd4,
    PH_RUNVAL   = 4'd5,
    PH_LITFIRST = 4'd6,
    PH_LITREST  = 4'd7,
    PH_FLAT     = 4'd8,
    PH_DONE     = 4'd9
  } phase_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_WIDTH = 2'd1,
    ST_COUNT = 2'd2
  } status_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd1;

  // Scanline header and code constants
  localparam logic [15:0] WIDTH_MIN   = 16'd8;
  localparam logic [15:0] WIDTH_MAX   = 16'h7fff;
  localparam logic [15:0] WIDTH_RST   = 16'd8;
  localparam logic [15:0] HEIGHT_RST  = 16'd1;
  localparam logic [7:0]  HDR_MAGIC   = 8'd2;
  localparam logic [7:0]  RUN_BASE    = 8'd128;
  localparam logic [1:0]  PLANE_LAST  = 2'd3;

  // One result item
  typedef struct packed {
    logic [7:0]  value;
    logic [6:0]  rep;
    logic [1:0]  plane;
    logic [15:0] column;
    logic        flat;
    logic        se;
    logic        ie;
    status_e     status;
  } res_t;

  // What one decode step hands to the output stage
  typedef struct packed {
    logic            emit;   // a result is produced
    logic            burst;  // fallback: three more flat bytes follow
    res_t            res;
    logic [2:0][7:0] vals;   // values of the burst beats, lowest first
  } step_t;

endpackage : rgbe_rle_pkg
`default_nettype wire

// File: hdl/rgbe_scanline_rle_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rgbe_scanline_rle_decoder
// Radiance RGBE scanline run-length decoder, one pixel-data byte per item.
// -----------------------------------------------------------------------------
// Usage:
//   Feed the pixel-data bytes that follow the text header on the s_axis
//   channel, one byte per item; set tuser on the first byte of an image to
//   restart decoding. Each result item on m_axis is one byte value with the
//   run of positions it fills; tlast marks the item that completes a scanline.
//   Image width and height are written through the cfg port while the block
//   is idle; a write also restarts decoding.
// Timing:
//   An item moves from the input register through the decode step into the
//   result register, which drives m_axis. One byte is accepted every cycle
//   while the receiver keeps up. A fallback scanline header yields four
//   results from one byte; the result register plays them out in turn and
//   the input holds until the last of them is being taken.
// Reset:
//   Width 8, height 1, decoder waiting for the first scanline header, both
//   channels empty.
// Stalls:
//   When m_axis_tready_i is low the result holds; the input register takes
//   one more byte and then s_axis_tready_o drops until the result drains.
// -----------------------------------------------------------------------------
module rgbe_scanline_rle_decoder (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration writes
  input  wire logic                               cfg_we_i,
  input  wire logic [rgbe_rle_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [15:0]                        cfg_data_i,
  // Byte input
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  input  wire logic [7:0]                         s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic                               s_axis_tuser_i,   // [0] start_image
  // Result output
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // [7:0] out_value, [14:8] repeat_count, [30:15] column, [31] zero
  output logic [31:0]                             m_axis_tdata_o,
  // [1:0] plane, [2] flat_mode, [3] image_end, [5:4] status
  output logic [5:0]                              m_axis_tuser_o,
  output logic                                    m_axis_tlast_o    // scanline_end
);
  import rgbe_rle_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;
  logic       ob_ready;
  logic       adv;
  step_t      step;
  res_t       res;

  // Input register
  assign adv             = in_valid_q && ob_ready;
  assign s_axis_tready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q  <= s_axis_tdata_i;
      in_start_q <= s_axis_tuser_i;
    end
  end

  // Decode step
  rgbe_rle_step u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .adv_i      (adv),
    .byte_i     (in_byte_q),
    .start_i    (in_start_q),
    .step_o     (step)
  );

  // Result register
  rgbe_rle_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv && step.emit),
    .step_i  (step),
    .ready_o (ob_ready),
    .valid_o (m_axis_tvalid_o),
    .take_i  (m_axis_tready_i),
    .res_o   (res)
  );

  // Pack the result item
  assign m_axis_tdata_o = {1'b0, res.column, res.rep, res.value};
  assign m_axis_tuser_o = {res.status, res.ie, res.flat, res.plane};
  assign m_axis_tlast_o = res.se;

endmodule : rgbe_scanline_rle_decoder
`default_nettype wire

// File: hdl/rgbe_rle_step.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rgbe_rle_step
// Decoder state, configuration registers and the per-byte state update.
// -----------------------------------------------------------------------------
module rgbe_rle_step (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [rgbe_rle_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [15:0]                        cfg_data_i,
  input  wire logic                               adv_i,
  input  wire logic [7:0]                         byte_i,
  input  wire logic                               start_i,
  output rgbe_rle_pkg::step_t                     step_o
);
  import rgbe_rle_pkg::*;

  // Configuration and decoder state
  logic [15:0] width_q, height_q;
  phase_e      phase_q, phase_d;
  logic [7:0]  h0_q, h1_q, h2_q, h0_d, h1_d, h2_d;
  logic [1:0]  plane_q, plane_d;
  logic [15:0] col_q, col_d;
  logic [7:0]  lit_q, lit_d;
  logic [6:0]  run_q, run_d;
  logic [15:0] lines_q, lines_d;

  // State as seen by this byte, after an optional restart
  phase_e      e_phase;
  logic [7:0]  e_h0, e_h1, e_h2;
  logic [1:0]  e_plane;
  logic [15:0] e_col;
  logic [7:0]  e_lit;
  logic [6:0]  e_run;
  logic [15:0] e_lines;

  // Shared helpers
  logic        flat_width;
  logic [16:0] fl_col_inc;
  logic        fl_wrap, fl_se, fl_ie;
  logic [1:0]  fl_plane;
  logic [15:0] fl_col;
  logic [15:0] fl_lines;
  logic [7:0]  chk_len;
  logic [16:0] chk_sum;
  logic        chk_bad;
  logic [6:0]  eu_len;
  logic [16:0] eu_sum;
  logic        eu_wrap, eu_se, eu_ie;
  logic [1:0]  eu_plane;
  logic [15:0] eu_col;
  logic [15:0] eu_lines;
  phase_e      eu_phase;
  logic [7:0]  lit_dec;
  logic [15:0] hdr_width;
  step_t       step;

  // Restart on a start flag
  always_comb begin
    if (start_i) begin
      e_phase = PH_HDR0;
      e_h0    = '0;
      e_h1    = '0;
      e_h2    = '0;
      e_plane = '0;
      e_col   = '0;
      e_lit   = '0;
      e_run   = '0;
      e_lines = height_q;
    end else begin
      e_phase = phase_q;
      e_h0    = h0_q;
      e_h1    = h1_q;
      e_h2    = h2_q;
      e_plane = plane_q;
      e_col   = col_q;
      e_lit   = lit_q;
      e_run   = run_q;
      e_lines = lines_q;
    end
  end

  // Advance one flat byte
  assign flat_width = (width_q < WIDTH_MIN) || (width_q > WIDTH_MAX);
  assign fl_wrap    = (e_plane == PLANE_LAST);
  assign fl_plane   = e_plane + 2'd1;
  assign fl_col_inc = {1'b0, e_col} + 17'd1;
  assign fl_se      = fl_wrap && (fl_col_inc >= {1'b0, width_q});
  assign fl_ie      = fl_se && (e_lines <= 16'd1);
  assign fl_col     = fl_se ? '0 : (fl_wrap ? fl_col_inc[15:0] : e_col);
  assign fl_lines   = (fl_se && e_lines != '0) ? e_lines - 16'd1 : e_lines;

  // Check a run or literal count against the room left in the plane
  assign chk_len = (e_phase == PH_RUNVAL) ? {1'b0, e_run} : e_lit;
  assign chk_sum = {1'b0, e_col} + {9'd0, chk_len};
  assign chk_bad = (chk_len == '0) || (chk_sum > {1'b0, width_q});

  // Close a run or a literal and move along the plane
  assign eu_len   = (e_phase == PH_RUNVAL) ? e_run : 7'd1;
  assign eu_sum   = {1'b0, e_col} + {10'd0, eu_len};
  assign eu_wrap  = (eu_sum >= {1'b0, width_q});
  assign eu_se    = eu_wrap && (e_plane == PLANE_LAST);
  assign eu_ie    = eu_se && (e_lines <= 16'd1);
  assign eu_col   = eu_wrap ? '0 : eu_sum[15:0];
  assign eu_plane = eu_wrap ? e_plane + 2'd1 : e_plane;
  assign eu_lines = (eu_se && e_lines != '0) ? e_lines - 16'd1 : e_lines;
  assign eu_phase = eu_ie ? PH_DONE : (eu_se ? PH_HDR0 : PH_CODE);

  assign lit_dec   = e_lit - 8'd1;
  assign hdr_width = {e_h2, byte_i};

  // Next state and result for this byte
  always_comb begin
    phase_d = e_phase;
    h0_d    = e_h0;
    h1_d    = e_h1;
    h2_d    = e_h2;
    plane_d = e_plane;
    col_d   = e_col;
    lit_d   = e_lit;
    run_d   = e_run;
    lines_d = e_lines;

    step            = '0;
    step.res.value  = byte_i;
    step.res.rep    = 7'd1;
    step.res.plane  = e_plane;
    step.res.column = e_col;
    step.res.status = ST_OK;

    unique case (e_phase)
      PH_HDR0: begin
        if (e_lines == '0 || width_q == '0) begin
          phase_d = PH_DONE;
        end else if (flat_width) begin
          step.emit    = 1'b1;
          step.res.flat = 1'b1;
          step.res.se  = fl_se;
          step.res.ie  = fl_ie;
          plane_d      = fl_plane;
          col_d        = fl_col;
          lines_d      = fl_lines;
          phase_d      = fl_ie ? PH_DONE : PH_FLAT;
        end else begin
          h0_d    = byte_i;
          phase_d = PH_HDR1;
        end
      end
      PH_HDR1: begin
        h1_d    = byte_i;
        phase_d = PH_HDR2;
      end
      PH_HDR2: begin
        h2_d    = byte_i;
        phase_d = PH_HDR3;
      end
      PH_HDR3: begin
        if (e_h0 != HDR_MAGIC || e_h1 != HDR_MAGIC || e_h2[7]) begin
          // Fall back to flat pixels; the header is the first pixel
          step.emit       = 1'b1;
          step.burst      = 1'b1;
          step.res.value  = e_h0;
          step.res.plane  = '0;
          step.res.column = '0;
          step.res.flat   = 1'b1;
          step.vals       = {byte_i, e_h2, e_h1};
          plane_d         = '0;
          col_d           = 16'd1;
          phase_d         = PH_FLAT;
        end else if (hdr_width != width_q) begin
          step.emit       = 1'b1;
          step.res.value  = '0;
          step.res.rep    = '0;
          step.res.status = ST_WIDTH;
          phase_d         = PH_DONE;
        end else begin
          plane_d = '0;
          col_d   = '0;
          phase_d = PH_CODE;
        end
      end
      PH_CODE: begin
        if (byte_i > RUN_BASE) begin
          run_d   = byte_i[6:0];
          phase_d = PH_RUNVAL;
        end else begin
          lit_d   = byte_i;
          phase_d = PH_LITFIRST;
        end
      end
      PH_RUNVAL: begin
        step.emit = 1'b1;
        if (chk_bad) begin
          step.res.value  = '0;
          step.res.rep    = '0;
          step.res.status = ST_COUNT;
          phase_d         = PH_DONE;
        end else begin
          step.res.rep = e_run;
          step.res.se  = eu_se;
          step.res.ie  = eu_ie;
          plane_d      = eu_plane;
          col_d        = eu_col;
          lines_d      = eu_lines;
          phase_d      = eu_phase;
        end
      end
      PH_LITFIRST, PH_LITREST: begin
        step.emit = 1'b1;
        if (e_phase == PH_LITFIRST && chk_bad) begin
          step.res.value  = '0;
          step.res.rep    = '0;
          step.res.status = ST_COUNT;
          phase_d         = PH_DONE;
        end else begin
          lit_d = lit_dec;
          if (lit_dec == '0) begin
            step.res.se = eu_se;
            step.res.ie = eu_ie;
            plane_d     = eu_plane;
            col_d       = eu_col;
            lines_d     = eu_lines;
            phase_d     = eu_phase;
          end else begin
            col_d   = fl_col_inc[15:0];
            phase_d = PH_LITREST;
          end
        end
      end
      PH_FLAT: begin
        step.emit     = 1'b1;
        step.res.flat = 1'b1;
        step.res.se   = fl_se;
        step.res.ie   = fl_ie;
        plane_d       = fl_plane;
        col_d         = fl_col;
        lines_d       = fl_lines;
        phase_d       = fl_ie ? PH_DONE : PH_FLAT;
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase
  end

  assign step_o = step;

  // Hold configuration and state; a register write restarts decoding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      phase_q  <= PH_HDR0;
      h0_q     <= '0;
      h1_q     <= '0;
      h2_q     <= '0;
      plane_q  <= '0;
      col_q    <= '0;
      lit_q    <= '0;
      run_q    <= '0;
      lines_q  <= HEIGHT_RST;
    end else if (cfg_we_i && (cfg_idx_i == CFG_WIDTH || cfg_idx_i == CFG_HEIGHT)) begin
      if (cfg_idx_i == CFG_WIDTH) begin
        width_q <= cfg_data_i;
        lines_q <= height_q;
      end else begin
        height_q <= cfg_data_i;
        lines_q  <= cfg_data_i;
      end
      phase_q <= PH_HDR0;
      h0_q    <= '0;
      h1_q    <= '0;
      h2_q    <= '0;
      plane_q <= '0;
      col_q   <= '0;
      lit_q   <= '0;
      run_q   <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      h0_q    <= h0_d;
      h1_q    <= h1_d;
      h2_q    <= h2_d;
      plane_q <= plane_d;
      col_q   <= col_d;
      lit_q   <= lit_d;
      run_q   <= run_d;
      lines_q <= lines_d;
    end
  end

endmodule : rgbe_rle_step
`default_nettype wire

// File: hdl/rgbe_rle_outbuf.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rgbe_rle_outbuf
// Result register; plays out the four-beat fallback pixel one item a cycle while the receiver takes them.
// -----------------------------------------------------------------------------
module rgbe_rle_outbuf (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire rgbe_rle_pkg::step_t  step_i,
  output logic                      ready_o,
  output logic                      valid_o,
  input  wire logic                 take_i,
  output rgbe_rle_pkg::res_t        res_o
);
  import rgbe_rle_pkg::*;

  logic            valid_q, valid_d;
  logic [1:0]      beats_q, beats_d;
  res_t            res_q, res_d;
  logic [2:0][7:0] vals_q, vals_d;
  logic            fire;

  assign fire    = valid_q && take_i;
  assign ready_o = !valid_q || (take_i && beats_q == '0);

  // Load a new result, or step through the burst beats
  always_comb begin
    valid_d = valid_q;
    beats_d = beats_q;
    res_d   = res_q;
    vals_d  = vals_q;
    if (load_i) begin
      valid_d = 1'b1;
      beats_d = step_i.burst ? 2'd3 : 2'd0;
      res_d   = step_i.res;
      vals_d  = step_i.vals;
    end else if (fire) begin
      if (beats_q != '0) begin
        beats_d     = beats_q - 2'd1;
        res_d.value = vals_q[0];
        res_d.plane = res_q.plane + 2'd1;
        vals_d      = {8'd0, vals_q[2], vals_q[1]};
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beats_q <= '0;
    end else begin
      valid_q <= valid_d;
      beats_q <= beats_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    vals_q <= vals_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule : rgbe_rle_outbuf
`default_nettype wire

// File: hdl/rgbe_rle_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rgbe_rle_chk
// Port-level checks on the result channel of the RGBE scanline decoder.
// -----------------------------------------------------------------------------
module rgbe_rle_chk (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  input  wire logic [31:0]                        m_axis_tdata_o,
  input  wire logic [5:0]                         m_axis_tuser_o,
  input  wire logic                               m_axis_tlast_o
);
  import rgbe_rle_pkg::*;

  logic out_stall;
  logic out_err;

  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_err   = m_axis_tuser_o[5:4] != ST_OK;

  // Hold a stalled result
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_stall |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_stall |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
                  && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  // Error items carry no run and no markers
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_err |->
      m_axis_tdata_o[14:8] == 7'd0 && !m_axis_tuser_o[2] && !m_axis_tuser_o[3]
      && !m_axis_tlast_o)
    else $error("malformed error item");

  // Flat bytes fill exactly one position
  a_flat_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[2] |->
      m_axis_tdata_o[14:8] == 7'd1 && !out_err)
    else $error("flat item with bad count");

  // Image end only comes with scanline end
  a_ie_se: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[3] |-> m_axis_tlast_o)
    else $error("image end without scanline end");

endmodule : rgbe_rle_chk

bind rgbe_scanline_rle_decoder rgbe_rle_chk u_rgbe_rle_chk (.*);
`default_nettype wire
